FILE: rtl/cba_pkg.sv
package cba_pkg;

  // Request kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Response status codes
  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_ZERO   = 2'd1,
    STAT_NOROOM = 2'd2,
    STAT_BADREL = 2'd3
  } status_t;

  // One block's entry in the map
  typedef struct packed {
    logic free;
    logic run_end;
  } blk_t;

  // Controller to ring: shift enable and the value written into the tail cell
  typedef struct packed {
    logic shift;
    blk_t tail;
  } ring_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FREE,
    ST_FIN
  } ctrl_state_t;

endpackage

FILE: rtl/cba_req_if.sv
interface cba_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] request_bytes;
  logic [11:0] release_offset;

  modport source (output valid, output kind, output request_bytes, output release_offset,
                  input ready);
  modport sink (input valid, input kind, input request_bytes, input release_offset,
                output ready);
endinterface

FILE: rtl/cba_rsp_if.sv
interface cba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] start_offset;

  modport source (output valid, output status, output start_offset, input ready);
  modport sink (input valid, input status, input start_offset, output ready);
endinterface

FILE: rtl/cba_cell.sv
module cba_cell
  import cba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  blk_t d,
  output blk_t q
);

  blk_t blk;

  // Reset: block free, not a run end
  always_ff @(posedge clk) begin
    if (rst) begin
      blk <= '{free: 1'b1, run_end: 1'b0};
    end else if (shift) begin
      blk <= d;
    end
  end

  assign q = blk;

endmodule

FILE: rtl/cba_ctrl.sv
module cba_ctrl
  import cba_pkg::*;
#(
  parameter int BLOCK_COUNT = 64,
  parameter int BLOCK_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  cba_req_if.sink     req,
  cba_rsp_if.source   rsp,
  input  blk_t        head,
  output ring_ctl_t   ring
);

  localparam int CW = (BLOCK_COUNT > 2) ? $clog2(BLOCK_COUNT) : 1;
  localparam int PW = $clog2(BLOCK_COUNT * BLOCK_BYTES + 1);
  localparam int AW = (PW > 16) ? PW : 16;
  localparam logic [CW-1:0] LAST_BLK = CW'(BLOCK_COUNT - 1);
  localparam logic [AW-1:0] BB = AW'(BLOCK_BYTES);

  ctrl_state_t state, state_next;

  logic [CW-1:0] pos_blk;      // block currently at the ring head
  logic [AW-1:0] pos_bytes;    // its byte offset
  logic [AW-1:0] len_bytes;    // bytes of free run seen so far
  logic [CW-1:0] first;
  logic [CW-1:0] last;
  logic [11:0]   first_base;
  logic          found;
  logic          freeing;
  logic          hit;
  logic          prev_free;
  logic          prev_end;
  logic [15:0]   bytes_r;
  logic [11:0]   offset_r;
  status_t       pend;
  logic          out_valid;
  status_t       out_status;
  logic [11:0]   out_start;

  logic          step_last;
  logic          accept;
  logic          fin_load;
  logic [AW-1:0] len_new;
  logic          fit_now;
  logic          sel;
  logic          rel_start;
  logic          in_mark;

  assign step_last = (pos_blk == LAST_BLK);
  assign accept    = (state == ST_IDLE) && req.valid;
  assign fin_load  = (state == ST_FIN) && (!out_valid || rsp.ready);
  assign len_new   = (len_bytes == '0) ? BB : (len_bytes + BB);
  assign fit_now   = head.free && !found && (len_new >= AW'(bytes_r));
  assign sel       = (AW'(offset_r) >= pos_bytes) && (AW'(offset_r) < (pos_bytes + BB));
  assign rel_start = sel && !head.free && (prev_free || prev_end);
  assign in_mark   = found && (pos_blk >= first) && (pos_blk <= last);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.kind == KIND_RELEASE) begin
            state_next = ST_FREE;
          end else if (req.request_bytes == '0) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: if (step_last) state_next = ST_MARK;
      ST_MARK: if (step_last) state_next = ST_FIN;
      ST_FREE: if (step_last) state_next = ST_FIN;
      ST_FIN:  if (fin_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and ring write-back
  always_comb begin
    req.ready  = (state == ST_IDLE);
    ring.shift = 1'b0;
    ring.tail  = head;
    unique case (state)
      ST_SCAN: ring.shift = 1'b1;
      ST_MARK: begin
        ring.shift = 1'b1;
        if (in_mark) begin
          ring.tail = '{free: 1'b0, run_end: (pos_blk == last)};
        end
      end
      ST_FREE: begin
        ring.shift = 1'b1;
        if (freeing || rel_start) begin
          ring.tail = '{free: 1'b1, run_end: 1'b0};
        end
      end
      default: ring.shift = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      bytes_r   <= req.request_bytes;
      offset_r  <= req.release_offset;
      pos_blk   <= '0;
      pos_bytes <= '0;
      len_bytes <= '0;
      found     <= 1'b0;
      freeing   <= 1'b0;
      hit       <= 1'b0;
      prev_free <= 1'b1;
      prev_end  <= 1'b0;
      pend      <= STAT_ZERO;
    end else if (ring.shift) begin
      pos_blk   <= step_last ? '0 : pos_blk + 1'b1;
      pos_bytes <= step_last ? '0 : pos_bytes + BB;
      prev_free <= head.free;
      prev_end  <= head.run_end;
      if (state == ST_SCAN && !found) begin
        if (head.free) begin
          len_bytes <= len_new;
          if (len_bytes == '0) begin
            first      <= pos_blk;
            first_base <= pos_bytes[11:0];
          end
          if (fit_now) begin
            found <= 1'b1;
            last  <= pos_blk;
          end
        end else begin
          len_bytes <= '0;
        end
      end
      if (state == ST_MARK && step_last) begin
        pend <= found ? STAT_DONE : STAT_NOROOM;
      end
      if (state == ST_FREE) begin
        if (freeing) begin
          if (head.run_end) freeing <= 1'b0;
        end else if (rel_start) begin
          hit     <= 1'b1;
          freeing <= !head.run_end;
        end
        if (step_last) begin
          pend <= (hit || rel_start) ? STAT_DONE : STAT_BADREL;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_status <= pend;
      out_start  <= found ? first_base : 12'd0;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.start_offset = out_start;

endmodule

FILE: rtl/contiguous_block_allocator_top.sv
// Channel | Dir | Payload                                   | Handshake
// req     | in  | kind, request_bytes[15:0], release_offset  | valid/ready
// rsp     | out | status[1:0], start_offset[11:0]           | valid/ready
//
// Phases: an allocate makes one ring turn to find the first fit and one to
// mark it, a release makes one turn, and a zero-size allocate makes none; the
// ring passes one block per cycle while it turns, under a single head position.
// Reset (rst, synchronous): every block free, no run ends, no response pending.
// A response waits in its output register; the next request is taken while it
// waits, and a finished request holds until that register is free.
module contiguous_block_allocator_top
  import cba_pkg::*;
#(
  parameter int BLOCK_COUNT = 64,
  parameter int BLOCK_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst,
  cba_req_if.sink   req,
  cba_rsp_if.source rsp
);

  // Ring of block cells: cell 0 is the head seen by the controller, each cell
  // takes its right neighbor's entry on a shift, and the controller writes the
  // (possibly updated) head entry back into the last cell. After BLOCK_COUNT
  // shifts every entry is back at its home cell.
  blk_t      cell_q [BLOCK_COUNT];
  ring_ctl_t ring;

  for (genvar i = 0; i < BLOCK_COUNT; i++) begin : g_cell
    blk_t d;
    if (i == BLOCK_COUNT - 1) begin : g_tail
      assign d = ring.tail;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end

    cba_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ring.shift),
      .d     (d),
      .q     (cell_q[i])
    );
  end

  // Sequencer: first-fit search, run marking, release walk, response register
  cba_ctrl #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .head (cell_q[0]),
    .ring (ring)
  );

endmodule

FILE: tb/contiguous_block_allocator_top_tb.sv
module contiguous_block_allocator_top_tb;
  import cba_pkg::*;

  localparam int BLOCK_COUNT = 64;
  localparam int BLOCK_BYTES = 64;

  // Slowest request is an allocate: two full turns of the ring plus overhead.
  localparam int ALLOC_CYCLES = 2 * BLOCK_COUNT + 2;
  localparam int NUM_RANDOM   = 1230;
  // Long receiver hold-off; block fills and back-pressures the request side.
  localparam int LONG_HOLD    = 600;
  // Quiet-cycle limit: long hold + worst latency + worst sender gap, several times over.
  localparam int QUIET_LIMIT  = 4 * (LONG_HOLD + ALLOC_CYCLES + 64);

  typedef struct packed {
    status_t     status;
    logic [11:0] start_offset;
  } alloc_rsp_t;

  // One directed request; when typed is set the expected result is the one
  // given in the row, otherwise the heap model supplies it.
  typedef struct packed {
    logic        kind;
    logic [15:0] bytes;
    logic [11:0] offset;
    logic        typed;
    status_t     status;
    logic [11:0] start_offset;
  } stim_row_t;

  localparam int NUM_DIRECTED = 23;

  // Heap layout after each row is noted where it matters.
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // zero size, offset field at its top value but ignored
    '{KIND_ALLOC,   16'd0,     12'hFFF, 1'b1, STAT_ZERO,   12'd0},
    // largest byte count, far beyond the heap
    '{KIND_ALLOC,   16'hFFFF,  12'd0,   1'b1, STAT_NOROOM, 12'd0},
    // one block more than the heap holds
    '{KIND_ALLOC,   16'd4097,  12'd0,   1'b1, STAT_NOROOM, 12'd0},
    // release on an empty heap, bytes field at its top value but ignored
    '{KIND_RELEASE, 16'hFFFF,  12'd0,   1'b1, STAT_BADREL, 12'd0},
    '{KIND_RELEASE, 16'd0,     12'hFFF, 1'b1, STAT_BADREL, 12'd0},
    // fill blocks 0, 1 and 2..3
    '{KIND_ALLOC,   16'd1,     12'd0,   1'b1, STAT_DONE,   12'd0},
    '{KIND_ALLOC,   16'd64,    12'd0,   1'b1, STAT_DONE,   12'd64},
    '{KIND_ALLOC,   16'd65,    12'd0,   1'b1, STAT_DONE,   12'd128},
    // unaligned release inside block 1
    '{KIND_RELEASE, 16'd0,     12'd69,  1'b0, STAT_DONE,   12'd0},
    // block 3 is the tail of a run, not its head
    '{KIND_RELEASE, 16'd0,     12'd192, 1'b1, STAT_BADREL, 12'd0},
    // first fit lands in the hole at block 1
    '{KIND_ALLOC,   16'd64,    12'hFFF, 1'b0, STAT_DONE,   12'd0},
    // 63 blocks wanted, only 60 left
    '{KIND_ALLOC,   16'd4000,  12'd0,   1'b1, STAT_NOROOM, 12'd0},
    // take the remaining 60 blocks, heap full
    '{KIND_ALLOC,   16'd3840,  12'd0,   1'b0, STAT_DONE,   12'd0},
    '{KIND_ALLOC,   16'd1,     12'd0,   1'b1, STAT_NOROOM, 12'd0},
    // last block is the tail of a run, not its head
    '{KIND_RELEASE, 16'd0,     12'hFFF, 1'b1, STAT_BADREL, 12'd0},
    '{KIND_RELEASE, 16'd0,     12'd256, 1'b0, STAT_DONE,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd0,   1'b0, STAT_DONE,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd127, 1'b0, STAT_DONE,   12'd0},
    '{KIND_RELEASE, 16'hFFFF,  12'd130, 1'b0, STAT_DONE,   12'd0},
    // whole heap in one run
    '{KIND_ALLOC,   16'd4096,  12'd0,   1'b1, STAT_DONE,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd4032, 1'b1, STAT_BADREL, 12'd0},
    '{KIND_RELEASE, 16'd0,     12'd0,   1'b0, STAT_DONE,   12'd0},
    // double release
    '{KIND_RELEASE, 16'd0,     12'd0,   1'b1, STAT_BADREL, 12'd0}
  };

  logic clk;
  logic rst;

  cba_req_if req_ch ();
  cba_rsp_if rsp_ch ();

  contiguous_block_allocator_top #(
    .BLOCK_COUNT(BLOCK_COUNT),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Heap model: free map and run-end map, updated once per accepted request.
  bit [BLOCK_COUNT-1:0] heap_free;
  bit [BLOCK_COUNT-1:0] heap_run_end;

  // Results still owed by the block, oldest first.
  alloc_rsp_t pending_results[$];

  int unsigned error_count;
  int unsigned burst_left;
  int          quiet_cycles;
  // Long hold-offs asked for by the sender, and those the receiver has served.
  int unsigned long_holds_asked;
  int unsigned long_holds_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A used block heads an allocation if it is block 0 or follows a free
  // block or a run end.
  function automatic bit is_alloc_head(int blk);
    if (heap_free[blk]) return 1'b0;
    if (blk == 0) return 1'b1;
    return heap_free[blk-1] || heap_run_end[blk-1];
  endfunction

  function automatic alloc_rsp_t apply_heap_request(logic kind, logic [15:0] bytes,
                                                    logic [11:0] offset);
    alloc_rsp_t  res;
    int          need;
    int          run_len;
    int          first;
    int          blk;
    bit          was_end;
    res.status       = STAT_DONE;
    res.start_offset = '0;
    if (kind == KIND_ALLOC) begin
      need = (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
      if (bytes == 16'd0) begin
        res.status = STAT_ZERO;
      end else if (need > BLOCK_COUNT) begin
        res.status = STAT_NOROOM;
      end else begin
        res.status = STAT_NOROOM;
        run_len    = 0;
        first      = 0;
        for (int b = 0; b < BLOCK_COUNT; b++) begin
          if (heap_free[b]) begin
            if (run_len == 0) first = b;
            run_len++;
            if (run_len == need) begin
              for (int k = first; k <= b; k++) begin
                heap_free[k]    = 1'b0;
                heap_run_end[k] = 1'b0;
              end
              heap_run_end[b]  = 1'b1;
              res.status       = STAT_DONE;
              res.start_offset = 12'(first * BLOCK_BYTES);
              break;
            end
          end else begin
            run_len = 0;
          end
        end
      end
    end else begin
      blk = int'(offset) / BLOCK_BYTES;
      if (blk >= BLOCK_COUNT || !is_alloc_head(blk)) begin
        res.status = STAT_BADREL;
      end else begin
        for (int b = blk; b < BLOCK_COUNT; b++) begin
          was_end         = heap_run_end[b];
          heap_free[b]    = 1'b1;
          heap_run_end[b] = 1'b0;
          if (was_end) break;
        end
      end
    end
    return res;
  endfunction

  function automatic bit pick_live_head(output int blk);
    int heads[$];
    for (int b = 0; b < BLOCK_COUNT; b++)
      if (is_alloc_head(b)) heads.push_back(b);
    blk = 0;
    if (heads.size() == 0) return 1'b0;
    blk = heads[$urandom_range(0, heads.size() - 1)];
    return 1'b1;
  endfunction

  // Mostly well-formed traffic: small allocations and releases of live heads,
  // with some odd sizes and stray releases mixed in.
  task automatic make_random_request(output logic kind, output logic [15:0] bytes,
                                     output logic [11:0] offset);
    int          used;
    int          roll;
    int          head;
    bit          want_release;
    used         = $countones(~heap_free);
    roll         = $urandom_range(0, 99);
    want_release = (used > 48) ? (roll < 70) : (roll < 40);
    bytes        = 16'($urandom_range(0, 16'hFFFF));
    offset       = 12'($urandom_range(0, 12'hFFF));
    if (!want_release) begin
      kind = KIND_ALLOC;
      roll = $urandom_range(0, 99);
      if (roll < 70)      bytes = 16'($urandom_range(1, 4 * BLOCK_BYTES));
      else if (roll < 85) bytes = 16'($urandom_range(1, 16 * BLOCK_BYTES));
      else if (roll < 90) bytes = 16'($urandom_range(16 * BLOCK_BYTES,
                                                     BLOCK_COUNT * BLOCK_BYTES));
      else if (roll < 95) bytes = 16'd0;
      // else keep the full-range byte count
    end else begin
      kind = KIND_RELEASE;
      if ($urandom_range(0, 99) < 80 && pick_live_head(head))
        offset = 12'(head * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1));
    end
  endtask

  // Offer one request and hold it until accepted; the model is advanced at
  // the accepting edge so the next random pick sees the updated heap.
  task automatic send_request(input logic kind, input logic [15:0] bytes,
                              input logic [11:0] offset, input bit typed,
                              input alloc_rsp_t typed_rsp);
    alloc_rsp_t predicted;
    req_ch.valid          <= 1'b1;
    req_ch.kind           <= kind;
    req_ch.request_bytes  <= bytes;
    req_ch.release_offset <= offset;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_heap_request(kind, bytes, offset);
    pending_results.push_back(typed ? typed_rsp : predicted);
  endtask

  // Bursts of back-to-back requests with random gaps; no gaps while the
  // receiver is in its long hold-off so the block really fills up.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else if (long_holds_asked == long_holds_done) begin
      burst_left = $urandom_range(0, 30);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Receiver: switches between always-ready, random and periodic stalls, and serves long hold-offs.
  initial begin : result_receiver
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    rsp_ch.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      mode   = $urandom_range(0, 2);
      span   = $urandom_range(30, 300);
      period = $urandom_range(2, 8);
      for (int i = 0; i < span; i++) begin
        if (long_holds_asked != long_holds_done) begin
          rsp_ch.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          long_holds_done++;
        end else begin
          case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 99) < 65);
            default: rsp_ch.ready <= ((i % period) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin : result_checker
    alloc_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d start_offset %0d",
               rsp_ch.status, rsp_ch.start_offset);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.start_offset !== want.start_offset) begin
          $error("start_offset: expected %0d, got %0d",
                 want.start_offset, rsp_ch.start_offset);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any request or result moving ends the run.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic        kind;
    logic [15:0] bytes;
    logic [11:0] offset;
    alloc_rsp_t  typed_rsp;
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.kind           = KIND_ALLOC;
    req_ch.request_bytes  = '0;
    req_ch.release_offset = '0;
    heap_free             = '1;
    heap_run_end          = '0;
    burst_left            = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: extremes, every status, the special cases.
    foreach (DIRECTED_ROWS[i]) begin
      typed_rsp.status       = DIRECTED_ROWS[i].status;
      typed_rsp.start_offset = DIRECTED_ROWS[i].start_offset;
      send_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].bytes,
                   DIRECTED_ROWS[i].offset, DIRECTED_ROWS[i].typed, typed_rsp);
      pace_sender();
    end
    // Sender pause: let every owed result come back before random traffic.
    drain_results();

    typed_rsp = '0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 200 || n == 800) long_holds_asked++;
      if (n == 600) drain_results();
      make_random_request(kind, bytes, offset);
      send_request(kind, bytes, offset, 1'b0, typed_rsp);
      pace_sender();
    end

    drain_results();
    // Any stray result after the last expected one is caught by the checker.
    repeat (ALLOC_CYCLES + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
